### hdl/clsr_pkg.sv
// Package with the constants of the combined congruential generator with shuffle table.
`default_nettype none

package clsr_pkg;

	// Moduli of the two generators, both just below 2**31.
	localparam logic [30:0] MOD_ONE = 31'd2147483563;
	localparam logic [30:0] MOD_TWO = 31'd2147483399;

	// Multipliers of the two generators.
	localparam logic [15:0] MUL_ONE = 16'd40014;
	localparam logic [15:0] MUL_TWO = 16'd40692;

	// Distance of each modulus from 2**31, used to fold the upper product bits back in.
	localparam logic [7:0] FOLD_ONE = 8'd85;
	localparam logic [7:0] FOLD_TWO = 8'd249;

	// Largest output value; the output wraps into 1..OUT_MAX.
	localparam logic [30:0] OUT_MAX = 31'd2147483562;

	// Value of the second generator after reset.
	localparam logic [30:0] SECOND_RESET = 31'd123456789;

	// Warm-up steps beyond the table size at initialization.
	localparam int WARMUP_EXTRA = 8;

	// Default number of shuffle table entries.
	localparam int TABLE_ENTRIES_DEF = 32;

endpackage

`default_nettype wire

### hdl/combined_lcg_shuffle_rng_core.sv
// Combined congruential random generator with shuffle table, integer output.
// A plain draw runs two modular multiplies (multiply, fold, correct) on the one shared
// unit, first generator then second, then a table read and an output step. A new request
// is stalled until the draw has loaded the output register. An initialization first adds
// TABLE_ENTRIES + 8 warm-up steps of the first generator.
// Reset zeroes the first generator, presets the second and requests initialization.
`default_nettype none

module combined_lcg_shuffle_rng_core #(
	parameter int TABLE_ENTRIES = clsr_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_write,
	input  wire logic [30:0] seed_value,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        reseed,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [30:0]      random_value
);

	localparam int IDX_W   = $clog2(TABLE_ENTRIES);
	localparam int WARM_W  = $clog2(TABLE_ENTRIES + clsr_pkg::WARMUP_EXTRA);
	localparam int DCNT_W  = 2;
	localparam logic [31:0] SLOT_DIV =
		32'(1 + int'(clsr_pkg::OUT_MAX) / TABLE_ENTRIES);
	localparam logic [IDX_W:0] SLOT_RECIP =
		(IDX_W + 1)'(64'd2147483648 / 64'(SLOT_DIV));
	localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(2);
	localparam logic [WARM_W-1:0] WARM_LAST =
		WARM_W'(TABLE_ENTRIES + clsr_pkg::WARMUP_EXTRA - 1);
	localparam logic [WARM_W-1:0] WARM_TABLE = WARM_W'(TABLE_ENTRIES);
	localparam logic [IDX_W:0] SLOT_LIMIT = (IDX_W + 1)'(TABLE_ENTRIES);
	localparam logic [IDX_W-1:0] SLOT_MAX = IDX_W'(TABLE_ENTRIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_FOLD,
		ST_FIX,
		ST_READ,
		ST_OUT
	} state_t;

	state_t             state_q;
	logic               sel_q;
	logic               warm_q;
	logic [WARM_W-1:0]  step_q;
	logic [30:0]        seed_q;
	logic               init_pending_q;
	logic [30:0]        gen1_q;
	logic [30:0]        gen2_q;
	logic [30:0]        last_output_q;
	logic               out_valid_q;
	logic [30:0]        random_value_q;

	logic [46:0]        prod_q;
	logic [31:0]        fold_q;
	logic [30:0]        rd_q;

	logic [DCNT_W-1:0]  div_cnt_q;
	logic [30:0]        rem_q;
	logic [IDX_W-1:0]   quot_q;

	logic [30:0]        mem [TABLE_ENTRIES];

	// Shared unit operands and results.
	logic [30:0]        unit_arg;
	logic [15:0]        unit_mul;
	logic [7:0]         unit_fold;
	logic [30:0]        unit_mod;
	logic [30:0]        unit_res;
	logic [30:0]        start_val;

	logic               can_load;
	logic [31:0]        diff;
	logic [31:0]        wrapped;
	logic [30:0]        draw_res;
	logic [IDX_W-1:0]   slot;

	logic               div_start;
	logic [30:0]        div_src;
	logic [31:0]        div_back;
	logic [31:0]        div_rest;
	logic               div_take;

	logic               mem_we;
	logic [IDX_W-1:0]   mem_wa;
	logic [30:0]        mem_wd;

	// Operand selection of the shared modular multiplier.
	always_comb begin
		unit_arg  = sel_q ? gen2_q : gen1_q;
		unit_mul  = sel_q ? clsr_pkg::MUL_TWO : clsr_pkg::MUL_ONE;
		unit_fold = sel_q ? clsr_pkg::FOLD_TWO : clsr_pkg::FOLD_ONE;
		unit_mod  = sel_q ? clsr_pkg::MOD_TWO : clsr_pkg::MOD_ONE;
		unit_res  = (fold_q >= {1'b0, unit_mod}) ? 31'(fold_q - {1'b0, unit_mod})
			: fold_q[30:0];
	end

	// Initial generator value; a zero seed counts as one.
	assign start_val = (seed_q == 31'd0) ? 31'd1 : seed_q;

	// Output register may load when empty or when its result transfers now.
	assign can_load = !out_valid_q || !out_stall;

	// Slot number, saturated as a guard.
	assign slot = ({1'b0, quot_q} >= SLOT_LIMIT) ? SLOT_MAX : quot_q;

	// New output: table entry minus second generator, wrapped into 1..OUT_MAX.
	always_comb begin
		diff     = {1'b0, rd_q} - {1'b0, gen2_q};
		wrapped  = diff + {1'b0, clsr_pkg::OUT_MAX};
		draw_res = (diff[31] || diff == 32'd0) ? wrapped[30:0] : diff[30:0];
	end

	// The slot division starts as a draw begins its first multiply.
	always_comb begin
		div_start = 1'b0;
		div_src   = last_output_q;
		if (state_q == ST_IDLE && in_valid && !init_pending_q && !reseed) begin
			div_start = 1'b1;
		end else if (state_q == ST_FIX && warm_q && step_q == '0) begin
			div_start = 1'b1;
			div_src   = unit_res;
		end
	end

	// The reciprocal estimate is at most one below the true quotient; one compare fixes it.
	always_comb begin
		div_back = {{(32 - IDX_W){1'b0}}, quot_q} * SLOT_DIV;
		div_rest = {1'b0, rem_q} - div_back;
		div_take = (div_rest >= SLOT_DIV);
	end

	// Table write port: warm-up fill or refill of the drawn slot.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = slot;
		mem_wd = gen1_q;
		if (state_q == ST_FIX && warm_q && step_q < WARM_TABLE) begin
			mem_we = 1'b1;
			mem_wa = step_q[IDX_W-1:0];
			mem_wd = unit_res;
		end else if (state_q == ST_OUT && can_load) begin
			mem_we = 1'b1;
		end
	end

	// Shuffle table storage with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == ST_READ) begin
			rd_q <= mem[slot];
		end
	end

	// Datapath registers of the shared unit and the slot division.
	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_q <= {16'd0, unit_arg} * {31'd0, unit_mul};
		end
		if (state_q == ST_FOLD) begin
			fold_q <= 32'({16'd0, prod_q[46:31]} * {24'd0, unit_fold})
				+ {1'b0, prod_q[30:0]};
		end
		if (div_start) begin
			rem_q <= div_src;
		end else if (div_cnt_q == DIV_STEPS) begin
			quot_q <= IDX_W'(({{(IDX_W + 1){1'b0}}, rem_q} * {31'd0, SLOT_RECIP}) >> 31);
		end else if (div_cnt_q != '0) begin
			quot_q <= quot_q + IDX_W'(div_take);
		end
	end

	// Sequencer, generator state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			sel_q          <= 1'b0;
			warm_q         <= 1'b0;
			step_q         <= '0;
			seed_q         <= '0;
			init_pending_q <= 1'b1;
			gen1_q         <= '0;
			gen2_q         <= clsr_pkg::SECOND_RESET;
			last_output_q  <= '0;
			out_valid_q    <= 1'b0;
			random_value_q <= '0;
			div_cnt_q      <= '0;
		end else begin
			// Result transfer empties the output register unless a new result loads.
			if (out_valid_q && !out_stall && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end

			// Division step counter.
			if (div_start) begin
				div_cnt_q <= DIV_STEPS;
			end else if (div_cnt_q != '0) begin
				div_cnt_q <= div_cnt_q - 1'b1;
			end

			// Seed register write requests a fresh initialization.
			if (seed_write) begin
				seed_q         <= seed_value;
				init_pending_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sel_q   <= 1'b0;
						state_q <= ST_MUL;
						if (init_pending_q || reseed) begin
							gen1_q <= start_val;
							gen2_q <= start_val;
							warm_q <= 1'b1;
							step_q <= WARM_LAST;
						end else begin
							warm_q <= 1'b0;
						end
					end
				end
				ST_MUL: begin
					state_q <= ST_FOLD;
				end
				ST_FOLD: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					if (warm_q) begin
						gen1_q  <= unit_res;
						state_q <= ST_MUL;
						if (step_q == '0) begin
							last_output_q  <= unit_res;
							init_pending_q <= 1'b0;
							warm_q         <= 1'b0;
						end else begin
							step_q <= step_q - 1'b1;
						end
					end else if (!sel_q) begin
						gen1_q  <= unit_res;
						sel_q   <= 1'b1;
						state_q <= ST_MUL;
					end else begin
						gen2_q  <= unit_res;
						sel_q   <= 1'b0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (can_load) begin
						last_output_q  <= draw_res;
						random_value_q <= draw_res;
						out_valid_q    <= 1'b1;
						state_q        <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_stall     = (state_q != ST_IDLE);
	assign out_valid    = out_valid_q;
	assign random_value = random_value_q;

endmodule

`default_nettype wire

### bench/combined_lcg_shuffle_rng_checker.sv
// Checker that predicts every draw of the shuffled combined generator and compares the results.
`timescale 1ns / 1ps
`default_nettype none

module combined_lcg_shuffle_rng_checker #(
	parameter int TABLE_ENTRIES = clsr_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        seed_write,
	input  wire logic [30:0] seed_value,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic        reseed,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [30:0] random_value,
	output int               fail_count,
	output int               pending
);

	// Width of one shuffle slot's share of the output range.
	localparam longint SLOT_SPAN = 1 + longint'(clsr_pkg::OUT_MAX) / TABLE_ENTRIES;

	// Private copy of the generator state and the seed register.
	logic [30:0] seed_reg;
	logic [30:0] gen_a;
	logic [30:0] gen_b;
	logic [30:0] prev_draw;
	logic [30:0] shuffle [TABLE_ENTRIES];
	logic        init_due;

	// Draws predicted but not yet seen on the output channel.
	logic [30:0] draws_due [$];
	int          reported;

	// One congruential step: value times multiplier, reduced exactly.
	function automatic logic [30:0] mod_mul(input logic [30:0] v, input logic [15:0] m,
			input logic [30:0] md);
		longint unsigned prod;
		prod = 64'(v) * 64'(m);
		return 31'(prod % 64'(md));
	endfunction

	// Load the seed and run the warm-up steps that fill the shuffle table.
	function automatic void load_table();
		logic [30:0] start;
		int k;
		start = seed_reg;
		if (start == '0)
			start = 31'd1;
		gen_a = start;
		gen_b = start;
		for (k = TABLE_ENTRIES + clsr_pkg::WARMUP_EXTRA - 1; k >= 0; k--) begin
			gen_a = mod_mul(gen_a, clsr_pkg::MUL_ONE, clsr_pkg::MOD_ONE);
			if (k < TABLE_ENTRIES)
				shuffle[k] = gen_a;
		end
		prev_draw = shuffle[0];
		init_due = 1'b0;
	endfunction

	// Advance both generators, pick the slot from the previous draw and refill it.
	function automatic logic [30:0] next_draw(input logic force_init);
		longint slot;
		longint diff;
		if (init_due || force_init)
			load_table();
		gen_a = mod_mul(gen_a, clsr_pkg::MUL_ONE, clsr_pkg::MOD_ONE);
		gen_b = mod_mul(gen_b, clsr_pkg::MUL_TWO, clsr_pkg::MOD_TWO);
		slot = longint'(prev_draw) / SLOT_SPAN;
		if (slot >= TABLE_ENTRIES)
			slot = TABLE_ENTRIES - 1;
		diff = longint'(shuffle[slot]) - longint'(gen_b);
		if (diff < 1)
			diff += longint'(clsr_pkg::OUT_MAX);
		prev_draw = 31'(diff);
		shuffle[slot] = gen_a;
		return prev_draw;
	endfunction

	// Follow register writes and both channels; outputs are checked before new predictions.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_reg = '0;
			gen_a = '0;
			gen_b = clsr_pkg::SECOND_RESET;
			prev_draw = '0;
			for (int i = 0; i < TABLE_ENTRIES; i++)
				shuffle[i] = '0;
			init_due = 1'b1;
			draws_due.delete();
			reported = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (seed_write) begin
				seed_reg = seed_value;
				init_due = 1'b1;
			end

			// A result transfer must match the oldest outstanding draw.
			if (out_valid && !out_stall) begin
				if (draws_due.size() == 0) begin
					if (reported < 10)
						$display("%0t: unexpected result, random_value %0d", $time,
							random_value);
					reported++;
					fail_count <= fail_count + 1;
				end else begin
					logic [30:0] want;
					want = draws_due.pop_front();
					if (random_value !== want) begin
						if (reported < 10)
							$display("%0t: random_value mismatch, expected %0d, got %0d",
								$time, want, random_value);
						reported++;
						fail_count <= fail_count + 1;
					end
				end
			end

			// An input transfer produces exactly one draw.
			if (in_valid && !in_stall)
				draws_due.push_back(next_draw(reseed));

			pending <= draws_due.size();
		end
	end

endmodule

`default_nettype wire

### bench/tb_combined_lcg_shuffle_rng_core.sv
// Testbench top for the shuffled combined generator: stimulus, reset, stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none

module tb_combined_lcg_shuffle_rng_core;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        seed_write = 1'b0;
	logic [30:0] seed_value = '0;
	logic        in_valid = 1'b0;
	logic        reseed = 1'b0;
	logic        out_stall = 1'b0;
	wire         in_stall;
	wire         out_valid;
	wire  [30:0] random_value;

	int fail_count;
	int pending;

	// Percent of cycles in which the sender holds back and the receiver stalls.
	int tx_idle_pct = 25;
	int rx_idle_pct = 53;

	combined_lcg_shuffle_rng_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_write  (seed_write),
		.seed_value  (seed_value),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.reseed      (reseed),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_value(random_value)
	);

	combined_lcg_shuffle_rng_checker draw_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.seed_write  (seed_write),
		.seed_value  (seed_value),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.reseed      (reseed),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.random_value(random_value),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// The receiver stalls at random on every cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Offer one draw request, after random idle cycles, and hold it until the transfer.
	task automatic send_draw(input logic force_init);
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		reseed <= force_init;
		do @(posedge clk); while (in_stall);
	endtask

	// Stop offering requests and wait until every predicted draw has come out.
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// Seed writes happen only on an idle block.
	task automatic write_seed(input logic [30:0] v);
		drain();
		seed_write <= 1'b1;
		seed_value <= v;
		@(posedge clk);
		seed_write <= 1'b0;
	endtask

	// Seeds lean toward zero, the upper range limit and values above the range.
	function automatic logic [30:0] pick_seed();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			2: return clsr_pkg::MOD_ONE;
			3: return clsr_pkg::OUT_MAX;
			default: return 31'($urandom());
		endcase
	endfunction

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Draws from the reset seed, including a forced reinitialization.
		repeat (3) send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b0);

		// Smallest and largest seeds in range.
		write_seed(31'd1);
		repeat (2) send_draw(1'b0);
		write_seed(clsr_pkg::OUT_MAX);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b0);

		// Seed equal to the first modulus leaves the first generator at zero.
		write_seed(clsr_pkg::MOD_ONE);
		repeat (2) send_draw(1'b0);
		send_draw(1'b1);

		// All seed bits set, then back to zero which is taken as one.
		write_seed('1);
		repeat (2) send_draw(1'b0);
		write_seed('0);
		send_draw(1'b1);
		send_draw(1'b0);

		// Random part: three stall patterns, each with two seeds.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 25;
					rx_idle_pct = 53;
				end
				1: begin
					tx_idle_pct = 53;
					rx_idle_pct = 25;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			for (int seg = 0; seg < 2; seg++) begin
				write_seed(pick_seed());
				repeat (265) send_draw($urandom_range(19) == 0);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

`default_nettype wire

### files.f
hdl/clsr_pkg.sv
hdl/combined_lcg_shuffle_rng_core.sv
bench/combined_lcg_shuffle_rng_checker.sv
bench/tb_combined_lcg_shuffle_rng_core.sv
